[rtl/vtce_pkg.sv]
`default_nettype none
package vtce_pkg;

    localparam int NumSlots = 5;
    localparam int SlotW    = $clog2(NumSlots);
    localparam int CoordW   = 10;
    localparam int PosW     = 16;
    localparam int PartW    = 5;

    typedef logic [6:0] t_byte;

    typedef enum logic [2:0] {
        ACT_DRAW  = 3'd0,
        ACT_MOVE  = 3'd1,
        ACT_PLOT  = 3'd2,
        ACT_ALPHA = 3'd3,
        ACT_CLEAR = 3'd4
    } t_action;

    typedef struct packed {
        logic  [NumSlots-1:0] mask;
        t_byte [NumSlots-1:0] bytes;
    } t_burst;

    localparam logic [CoordW-1:0] XMax = 10'd1023;
    localparam logic [CoordW-1:0] YMax = 10'd767;

    localparam logic [1:0] TAG_HIGH  = 2'b01;
    localparam logic [1:0] TAG_LOW_Y = 2'b11;
    localparam logic [1:0] TAG_LOW_X = 2'b10;

    localparam t_byte CODE_US  = 7'o037;
    localparam t_byte CODE_GS  = 7'o035;
    localparam t_byte CODE_ESC = 7'o033;
    localparam t_byte CODE_FF  = 7'o014;
    localparam t_byte CODE_AT  = 7'h40;

endpackage
`default_nettype wire

[rtl/vtce_encode.sv]
`default_nettype none
module vtce_encode
    import vtce_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire logic [2:0]      i_action,
    input  wire logic [PosW-1:0] i_pos_x,
    input  wire logic [PosW-1:0] i_pos_y,
    output t_burst               o_burst
);

    t_byte r_prev_hy, r_prev_ly, r_prev_hx;
    t_byte n_prev_hy, n_prev_ly, n_prev_hx;

    logic [CoordW-1:0] ux, uy;
    t_byte             hy, ly, hx, lx;
    logic              send_hy, send_ly, send_hx;

    always_comb begin
        if (i_pos_x[PosW-1]) begin
            ux = '0;
        end else if (|i_pos_x[PosW-2:CoordW]) begin
            ux = XMax;
        end else begin
            ux = i_pos_x[CoordW-1:0];
        end
        if (i_pos_y[PosW-1]) begin
            uy = '0;
        end else if (i_pos_y[PosW-2:0] > {{(PosW-1-CoordW){1'b0}}, YMax}) begin
            uy = YMax;
        end else begin
            uy = i_pos_y[CoordW-1:0];
        end
    end

    assign hy = {TAG_HIGH,  uy[CoordW-1:PartW]};
    assign ly = {TAG_LOW_Y, uy[PartW-1:0]};
    assign hx = {TAG_HIGH,  ux[CoordW-1:PartW]};
    assign lx = {TAG_LOW_X, ux[PartW-1:0]};

    assign send_hy = (hy != r_prev_hy);
    assign send_hx = (hx != r_prev_hx);
    assign send_ly = (ly != r_prev_ly) || send_hx;

    always_comb begin
        o_burst   = '0;
        n_prev_hy = r_prev_hy;
        n_prev_ly = r_prev_ly;
        n_prev_hx = r_prev_hx;
        unique case (t_action'(i_action))
            ACT_DRAW, ACT_MOVE: begin
                o_burst.bytes = {lx, hx, ly, hy, CODE_GS};
                o_burst.mask  = {1'b1, send_hx, send_ly, send_hy,
                                 (t_action'(i_action) == ACT_MOVE)};
                n_prev_hy     = hy;
                n_prev_ly     = ly;
                n_prev_hx     = hx;
            end
            ACT_PLOT: begin
                o_burst.bytes[0] = CODE_GS;
                o_burst.bytes[1] = CODE_AT;
                o_burst.mask     = 5'b00011;
                n_prev_hy        = '0;
                n_prev_ly        = '0;
                n_prev_hx        = '0;
            end
            ACT_ALPHA: begin
                o_burst.bytes[0] = CODE_US;
                o_burst.mask     = 5'b00001;
            end
            ACT_CLEAR: begin
                o_burst.bytes[0] = CODE_ESC;
                o_burst.bytes[1] = CODE_FF;
                o_burst.mask     = 5'b00011;
            end
            default: begin
                o_burst = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_hy <= '0;
            r_prev_ly <= '0;
            r_prev_hx <= '0;
        end else if (i_load) begin
            r_prev_hy <= n_prev_hy;
            r_prev_ly <= n_prev_ly;
            r_prev_hx <= n_prev_hx;
        end
    end

endmodule
`default_nettype wire

[rtl/vector_terminal_coord_encoder_top.sv]
// Each command goes from its input transfer into the holding stage, then into the
// output byte register, which offers its first byte. Throughput: one output byte per
// cycle while i_m_axis_tready is high; a command emits 1 to 5 bytes, or none and is dropped.
// A one-command holding stage sits ahead of the output byte register.
// Reset: synchronous, active low; clears remembered address bytes and both stages.
`default_nettype none
module vector_terminal_coord_encoder_top
    import vtce_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // pos_x[15:0], pos_y[31:16]
    input  wire logic [2:0]  i_s_axis_tuser,  // action[2:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,  // out_byte[6:0], zero[7]
    output logic             o_m_axis_tlast   // last
);

    t_burst                  new_burst;
    logic [NumSlots-1:0]     r_pend_mask, n_pend_mask;
    t_byte [NumSlots-1:0]    r_pend_bytes;
    logic [NumSlots-1:0]     r_out_mask, n_out_mask;
    t_byte [NumSlots-1:0]    r_out_bytes;
    logic [SlotW-1:0]        out_idx;
    logic                    in_take, out_take, out_last, out_free;

    vtce_encode u_encode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_take),
        .i_action (i_s_axis_tuser),
        .i_pos_x  (i_s_axis_tdata[15:0]),
        .i_pos_y  (i_s_axis_tdata[31:16]),
        .o_burst  (new_burst)
    );

    always_comb begin
        out_idx = '0;
        for (int i = NumSlots - 1; i >= 0; i--) begin
            if (r_out_mask[i]) begin
                out_idx = SlotW'(i);
            end
        end
    end

    assign out_last        = ((r_out_mask & (r_out_mask - 1'b1)) == '0);
    assign o_m_axis_tvalid = |r_out_mask;
    assign o_m_axis_tdata  = {1'b0, r_out_bytes[out_idx]};
    assign o_m_axis_tlast  = out_last;
    assign out_take        = o_m_axis_tvalid && i_m_axis_tready;
    assign out_free        = !o_m_axis_tvalid || (out_take && out_last);
    assign o_s_axis_tready = !(|r_pend_mask) || out_free;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_out_mask  = r_out_mask;
        n_pend_mask = r_pend_mask;
        if (out_free) begin
            n_out_mask  = r_pend_mask;
            n_pend_mask = '0;
        end else if (out_take) begin
            n_out_mask = r_out_mask & (r_out_mask - 1'b1);
        end
        if (in_take) begin
            n_pend_mask = new_burst.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_mask <= '0;
            r_out_mask  <= '0;
        end else begin
            r_pend_mask <= n_pend_mask;
            r_out_mask  <= n_out_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_bytes <= r_pend_bytes;
        end
        if (in_take) begin
            r_pend_bytes <= new_burst.bytes;
        end
    end

`ifndef SYNTHESIS
    a_pend_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|r_pend_mask && !out_free) |-> !o_s_axis_tready)
        else $error("input taken while holding stage busy");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && !out_last) |=> o_m_axis_tvalid)
        else $error("command bytes cut short");

    a_pend_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_axis_tvalid && |r_pend_mask) |=> o_m_axis_tvalid)
        else $error("held command not moved to output");
`endif

endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
    import vtce_pkg::*;

    typedef struct {
        t_byte code;
        logic  fin;
    } t_stream_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_data = '0;
    logic [2:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [7:0]  m_data;
    logic        m_last;

    t_stream_byte stream_q[$];
    t_stream_byte want_byte;
    t_byte        seen_hy = '0;
    t_byte        seen_ly = '0;
    t_byte        seen_hx = '0;
    logic         steady = 1'b0;
    int           errors = 0;
    logic [15:0]  cur_x = '0;
    logic [15:0]  cur_y = '0;

    vector_terminal_coord_encoder_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),  // pos_x[15:0], pos_y[31:16]
        .i_s_axis_tuser  (s_user),  // action[2:0]
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),  // out_byte[6:0], zero[7]
        .o_m_axis_tlast  (m_last)   // last
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    function automatic logic [9:0] clamp_coord(input logic signed [15:0] v,
                                               input logic [9:0] hi);
        if (v < 0)
            return '0;
        if (v > $signed({6'd0, hi}))
            return hi;
        return v[9:0];
    endfunction

    function automatic void encode_cmd(input logic [2:0] act, input logic [15:0] px,
                                       input logic [15:0] py);
        t_byte      burst[NumSlots];
        int         n;
        logic [9:0] cx;
        logic [9:0] cy;
        t_byte      hy;
        t_byte      ly;
        t_byte      hx;
        t_byte      lx;
        t_stream_byte item;
        n = 0;
        if (act == ACT_MOVE || act == ACT_PLOT) begin
            burst[n] = CODE_GS;
            n++;
        end
        if (act == ACT_DRAW || act == ACT_MOVE) begin
            cx = clamp_coord(px, XMax);
            cy = clamp_coord(py, YMax);
            hy = {TAG_HIGH, cy[9:5]};
            ly = {TAG_LOW_Y, cy[4:0]};
            hx = {TAG_HIGH, cx[9:5]};
            lx = {TAG_LOW_X, cx[4:0]};
            if (hy != seen_hy) begin
                burst[n] = hy;
                n++;
            end
            if (ly != seen_ly || hx != seen_hx) begin
                burst[n] = ly;
                n++;
            end
            if (hx != seen_hx) begin
                burst[n] = hx;
                n++;
            end
            burst[n] = lx;
            n++;
            seen_hy = hy;
            seen_ly = ly;
            seen_hx = hx;
        end else if (act == ACT_PLOT) begin
            burst[n] = CODE_AT;
            n++;
            seen_hy = '0;
            seen_ly = '0;
            seen_hx = '0;
        end else if (act == ACT_ALPHA) begin
            burst[n] = CODE_US;
            n++;
        end else if (act == ACT_CLEAR) begin
            burst[n] = CODE_ESC;
            burst[n + 1] = CODE_FF;
            n += 2;
        end
        for (int i = 0; i < n; i++) begin
            item.code = burst[i];
            item.fin  = (i == n - 1);
            stream_q.push_back(item);
        end
    endfunction

    task automatic send_cmd(input logic [2:0] act, input logic [15:0] px,
                            input logic [15:0] py);
        while (!steady && $urandom_range(0, 99) < 24) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {py, px};
        s_user  <= act;
        do @(posedge i_clk); while (!s_ready);
        encode_cmd(act, px, py);
    endtask

    task automatic drain_stream();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (stream_q.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (stream_q.size() == 0) begin
                    report_mismatch("unexpected byte", int'(m_data), 0);
                end else begin
                    want_byte = stream_q.pop_front();
                    if (m_data[6:0] != want_byte.code)
                        report_mismatch("out_byte", int'(m_data[6:0]),
                                        int'(want_byte.code));
                    if (m_data[7] != 1'b0)
                        report_mismatch("tdata pad bit", int'(m_data[7]), 0);
                    if (m_last != want_byte.fin)
                        report_mismatch("tlast", int'(m_last), int'(want_byte.fin));
                end
            end
            m_ready <= steady || ($urandom_range(0, 99) >= 24);
        end
    end

    function automatic logic [15:0] next_coord(input logic [15:0] prev, input int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return prev + 16'($urandom_range(0, 6)) - 16'd3;
        if (r < 75)
            return 16'($urandom_range(0, hi));
        if (r < 83)
            return 16'(hi - 2 + $urandom_range(0, 4));
        if (r < 90)
            return 16'($urandom_range(0, 4)) - 16'd2;
        return 16'($urandom);
    endfunction

    function automatic logic [2:0] pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return ACT_DRAW;
        if (r < 75)
            return ACT_MOVE;
        if (r < 82)
            return ACT_PLOT;
        if (r < 89)
            return ACT_ALPHA;
        if (r < 96)
            return ACT_CLEAR;
        return 3'($urandom_range(5, 7));
    endfunction

    task automatic send_random(input int count);
        int          sent;
        logic [2:0]  act;
        sent = 0;
        while (sent < count) begin
            act   = pick_action();
            cur_x = next_coord(cur_x, 1023);
            cur_y = next_coord(cur_y, 767);
            send_cmd(act, cur_x, cur_y);
            if (act <= ACT_CLEAR)
                sent++;
        end
    endtask

    task automatic test_directed();
        send_cmd(ACT_DRAW, 16'd0, 16'd0);
        send_cmd(ACT_DRAW, 16'd0, 16'd0);
        send_cmd(ACT_DRAW, 16'd1023, 16'd767);
        send_cmd(ACT_DRAW, 16'h7fff, 16'h7fff);
        send_cmd(ACT_DRAW, 16'h8000, 16'h8000);
        send_cmd(ACT_DRAW, 16'd1024, 16'd768);
        send_cmd(ACT_DRAW, 16'hffff, 16'hffff);
        send_cmd(ACT_DRAW, 16'd5, 16'd3);
        send_cmd(ACT_DRAW, 16'd37, 16'd3);
        send_cmd(ACT_DRAW, 16'd37, 16'd35);
        send_cmd(ACT_MOVE, 16'd37, 16'd35);
        send_cmd(ACT_MOVE, 16'd600, 16'd400);
        send_cmd(ACT_PLOT, 16'hffff, 16'h0000);
        send_cmd(ACT_DRAW, 16'd600, 16'd400);
        send_cmd(ACT_ALPHA, 16'h0000, 16'hffff);
        send_cmd(ACT_CLEAR, 16'h5555, 16'haaaa);
        send_cmd(3'd5, 16'd1, 16'd1);
        send_cmd(3'd6, 16'd2, 16'd2);
        send_cmd(3'd7, 16'd3, 16'd3);
        send_cmd(ACT_DRAW, 16'd600, 16'd401);
        send_cmd(ACT_MOVE, 16'd31, 16'd31);
        send_cmd(ACT_DRAW, 16'd32, 16'd32);
    endtask

    task automatic test_random();
        send_random(150);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        send_random(40);
        steady = 1'b0;
    endtask

    task automatic test_drain_pause();
        send_random(10);
        drain_stream();
        send_random(10);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_back_to_back();
        test_drain_pause();
        drain_stream();
        repeat (8) @(posedge i_clk);
        if (stream_q.size() != 0)
            report_mismatch("bytes never sent", stream_q.size(), 0);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
